>>> hw/rtl/spco_pkg.sv
// ----------------------------------------------------------------------------
// Scanout pixel and cursor overlay package
// Shared sizes, operation and register codes, and payload types.
// ----------------------------------------------------------------------------
package spco_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int CURSOR_SIZE     = 64;

    localparam int PAL_AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CUR_AW   = $clog2(CURSOR_SIZE);
    localparam int ROW_BITS = 64;
    localparam int COLOR_W  = 24;
    localparam int SKIP_W   = 6;
    localparam int ORIGIN_W = 16;
    localparam int COORD_W  = 11;
    localparam int COL_SEL_W = $clog2(ROW_BITS);

    // Item operation codes; the fourth code is ignored.
    localparam logic [1:0] OP_PIXEL   = 2'd0;
    localparam logic [1:0] OP_PALETTE = 2'd1;
    localparam logic [1:0] OP_CURSOR  = 2'd2;

    typedef enum logic [2:0] {
        REG_PIXEL_FORMAT      = 3'd0,
        REG_CURSOR_ENABLE     = 3'd1,
        REG_CURSOR_X          = 3'd2,
        REG_CURSOR_Y          = 3'd3,
        REG_CURSOR_SKIP_COLS  = 3'd4,
        REG_CURSOR_SKIP_ROWS  = 3'd5,
        REG_CURSOR_COLOR_ZERO = 3'd6,
        REG_CURSOR_COLOR_ONE  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [31:0]         pixel_word;
        logic                pixel_in_memory;
        logic [7:0]          table_index;
        logic [COLOR_W-1:0]  palette_color;
        logic [ROW_BITS-1:0] cursor_and_row;
        logic [ROW_BITS-1:0] cursor_xor_row;
        logic                cursor_row_valid;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } result_t;

    typedef struct packed {
        logic              hit;
        logic [CUR_AW-1:0] pos;
    } cursor_pos_t;

endpackage

>>> hw/rtl/spco_cursor_pos.sv
// ----------------------------------------------------------------------------
// Cursor position
// Maps one screen coordinate to a cursor row or column, with skip clipping.
// ----------------------------------------------------------------------------
module spco_cursor_pos (
    input  logic [spco_pkg::COORD_W-1:0]  coord,
    input  logic [spco_pkg::ORIGIN_W-1:0] origin,
    input  logic [spco_pkg::SKIP_W-1:0]   skip,
    output spco_pkg::cursor_pos_t         pos
);
    import spco_pkg::*;

    localparam int DW = ORIGIN_W + 1;

    logic [DW-1:0] diff;
    logic [DW-1:0] span;
    logic [DW-1:0] sum;
    logic          skip_ok;

    always_comb
    begin
        // The top bit of the difference is set when the coordinate lies left of
        // (or above) the origin.
        diff    = DW'(coord) - DW'(origin);
        skip_ok = DW'(skip) < DW'(CURSOR_SIZE);
        span    = DW'(CURSOR_SIZE) - DW'(skip);
        sum     = DW'(skip) + diff;
        pos.hit = skip_ok && !diff[DW-1] && (diff < span);
        pos.pos = sum[CUR_AW-1:0];
    end

endmodule

>>> hw/rtl/scanout_pixel_cursor_overlay_top.sv
// ----------------------------------------------------------------------------
// Scanout pixel and cursor overlay
// Converts framebuffer pixels to RGB through a palette or direct xRGB and
// draws a two-plane hardware cursor over them.
// ----------------------------------------------------------------------------
// An accepted pixel word passes the colour stage, then the result register.
// Throughput: one item per cycle while the result is not stalled, set by the
// registered read ports of the palette and cursor memories feeding a single
// colour stage. Write items produce no result.
// Reset clears config and valid registers and all cursor row loaded flags
// at once; palette and cursor planes are not cleared, and no pass clears them.
module scanout_pixel_cursor_overlay_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  spco_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output spco_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_data
);
    import spco_pkg::*;

    // Configuration registers.
    logic                pixel_format_reg;
    logic                cursor_enable_reg;
    logic [ORIGIN_W-1:0] cursor_x_reg;
    logic [ORIGIN_W-1:0] cursor_y_reg;
    logic [SKIP_W-1:0]   skip_cols_reg;
    logic [SKIP_W-1:0]   skip_rows_reg;
    logic [COLOR_W-1:0]  color_zero_reg;
    logic [COLOR_W-1:0]  color_one_reg;

    // Memories.
    logic [COLOR_W-1:0]  palette_mem [PALETTE_ENTRIES];
    logic [ROW_BITS-1:0] and_mem [CURSOR_SIZE];
    logic [ROW_BITS-1:0] xor_mem [CURSOR_SIZE];
    logic [CURSOR_SIZE-1:0] row_loaded_reg;

    // Colour stage registers.
    logic                s1_valid_reg;
    logic [COORD_W-1:0]  s1_x_reg;
    logic [COLOR_W-1:0]  s1_word_reg;
    logic                s1_in_mem_reg;
    logic                s1_idx_ok_reg;
    logic                s1_row_ok_reg;
    logic [COLOR_W-1:0]  s1_pal_reg;
    logic [ROW_BITS-1:0] s1_and_reg;
    logic [ROW_BITS-1:0] s1_xor_reg;

    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic        accept;
    logic        advance;
    logic        is_pixel;
    logic        pal_idx_ok;
    logic        cur_idx_ok;
    cursor_pos_t row_pos;
    cursor_pos_t col_pos;

    assign cfg_ready = 1'b1;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign is_pixel   = (item.op == OP_PIXEL);
    assign pal_idx_ok = {1'b0, item.table_index} < 9'(PALETTE_ENTRIES);
    assign cur_idx_ok = {1'b0, item.table_index} < 9'(CURSOR_SIZE);

    spco_cursor_pos u_row_pos (
        .coord  (item.pixel_y),
        .origin (cursor_y_reg),
        .skip   (skip_rows_reg),
        .pos    (row_pos)
    );

    spco_cursor_pos u_col_pos (
        .coord  (s1_x_reg),
        .origin (cursor_x_reg),
        .skip   (skip_cols_reg),
        .pos    (col_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg  <= 1'b0;
            cursor_enable_reg <= 1'b0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            skip_cols_reg     <= '0;
            skip_rows_reg     <= '0;
            color_zero_reg    <= '0;
            color_one_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PIXEL_FORMAT:      pixel_format_reg  <= cfg_data[0];
                REG_CURSOR_ENABLE:     cursor_enable_reg <= cfg_data[0];
                REG_CURSOR_X:          cursor_x_reg      <= cfg_data[ORIGIN_W-1:0];
                REG_CURSOR_Y:          cursor_y_reg      <= cfg_data[ORIGIN_W-1:0];
                REG_CURSOR_SKIP_COLS:  skip_cols_reg     <= cfg_data[SKIP_W-1:0];
                REG_CURSOR_SKIP_ROWS:  skip_rows_reg     <= cfg_data[SKIP_W-1:0];
                REG_CURSOR_COLOR_ZERO: color_zero_reg    <= cfg_data[COLOR_W-1:0];
                REG_CURSOR_COLOR_ONE:  color_one_reg     <= cfg_data[COLOR_W-1:0];
            endcase
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (accept && item.op == OP_PALETTE && pal_idx_ok)
            palette_mem[item.table_index[PAL_AW-1:0]] <= item.palette_color;
        if (accept && is_pixel)
            s1_pal_reg <= palette_mem[item.pixel_word[PAL_AW-1:0]];
    end

    // Cursor plane memories.
    always_ff @(posedge clk)
    begin
        if (accept && item.op == OP_CURSOR && cur_idx_ok)
        begin
            and_mem[item.table_index[CUR_AW-1:0]] <= item.cursor_and_row;
            xor_mem[item.table_index[CUR_AW-1:0]] <= item.cursor_xor_row;
        end
        if (accept && is_pixel)
        begin
            s1_and_reg <= and_mem[row_pos.pos];
            s1_xor_reg <= xor_mem[row_pos.pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_loaded_reg <= '0;
        else if (accept && item.op == OP_CURSOR && cur_idx_ok)
            row_loaded_reg[item.table_index[CUR_AW-1:0]] <= item.cursor_row_valid;
    end

    // The row test and loaded flag are sampled with the memory read, so a later
    // row write cannot alter a pixel already in flight.
    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
        begin
            s1_x_reg      <= item.pixel_x;
            s1_word_reg   <= item.pixel_word[COLOR_W-1:0];
            s1_in_mem_reg <= item.pixel_in_memory;
            s1_idx_ok_reg <= {1'b0, item.pixel_word[7:0]} < 9'(PALETTE_ENTRIES);
            s1_row_ok_reg <= cursor_enable_reg && row_pos.hit
                             && row_loaded_reg[row_pos.pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= is_pixel;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_comb
    begin
        logic [COLOR_W-1:0]   base;
        logic [COLOR_W-1:0]   shown;
        logic [COL_SEL_W-1:0] sel;
        logic                 and_bit;
        logic                 xor_bit;

        if (!s1_in_mem_reg)
            base = '0;
        else if (pixel_format_reg)
            base = s1_word_reg;
        else if (s1_idx_ok_reg)
            base = s1_pal_reg;
        else
            base = '0;

        // Column zero sits at the top bit of each plane row.
        sel     = COL_SEL_W'(ROW_BITS - 1) - COL_SEL_W'(col_pos.pos);
        and_bit = s1_and_reg[sel];
        xor_bit = s1_xor_reg[sel];

        shown = base;
        if (s1_row_ok_reg && col_pos.hit)
        begin
            if (!and_bit)
                shown = xor_bit ? color_one_reg : color_zero_reg;
            else if (xor_bit)
                shown = ~base;
        end

        result_next.red   = shown[23:16];
        result_next.green = shown[15:8];
        result_next.blue  = shown[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
